// ===== sv/gsbo_pkg.sv =====
// Package for the grouped stack band offset block: payload structs, codes, widths.
// No dependencies; used by every module of the block except gsbo_ram.
`default_nettype none
package gsbo_pkg;

  localparam int unsigned SumW = 40;
  localparam int unsigned OutW = 48;

  localparam logic [1:0] ModeZero      = 2'd0;
  localparam logic [1:0] ModeNormalize = 2'd1;
  localparam logic [1:0] ModeCenter    = 2'd2;

  localparam logic RegOffsetMode = 1'b0;
  localparam logic RegGrouping   = 1'b1;

  typedef struct packed {
    logic [15:0]        group_key;
    logic signed [31:0] sample_value;
    logic               final_row;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] band_lower;
    logic signed [OutW-1:0] band_upper;
    logic                   end_of_run;
    logic                   capacity_flag;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StDiv,
    StOut
  } emit_state_e;

endpackage
`default_nettype wire

// ===== sv/gsbo_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module gsbo_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = Depth > 1 ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write then register the read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/gsbo_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Uses gsbo_pkg for widths.
`default_nettype none
module gsbo_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [gsbo_pkg::SumW+15:0] num_i,
  input  wire logic signed [gsbo_pkg::SumW-1:0]  den_i,
  output logic                                   done_o,
  output logic signed [gsbo_pkg::SumW+15:0]      quo_o
);

  localparam int unsigned NW = gsbo_pkg::SumW + 16;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]                rem_q, rem_d, quo_q, quo_d, quo_nx;
  logic [gsbo_pkg::SumW-1:0]    den_q, den_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic                         busy_q, busy_d, neg_q, neg_d;
  logic [NW:0]                  trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    trial  = {rem_q, quo_q[NW-1]} - {{(NW+1-gsbo_pkg::SumW){1'b0}}, den_q};
    quo_nx = {quo_q[NW-2:0], ~trial[NW]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i[NW-1] ? NW'(-num_i) : num_i;
      den_d  = den_i[gsbo_pkg::SumW-1] ? gsbo_pkg::SumW'(-den_i) : den_i;
      neg_d  = num_i[NW-1] ^ den_i[gsbo_pkg::SumW-1];
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Shift in one dividend bit and try the subtraction
      if (!trial[NW]) begin
        rem_d = trial[NW-1:0];
      end else begin
        rem_d = {rem_q[NW-2:0], quo_q[NW-1]};
      end
      quo_d = quo_nx;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // Final quotient comes from the last step, even if a new start lands on it
  assign done_o = busy_q && (cnt_q == CW'(1));
  assign quo_o  = neg_q ? -$signed(quo_nx) : $signed(quo_nx);

endmodule
`default_nettype wire

// ===== sv/gsbo_front.sv =====
// Load front: group lookup, running sums, row store writes and run hand-off.
// Uses gsbo_pkg; feeds gsbo_back through the row RAMs and a run request.
`default_nettype none
module gsbo_front #(
  parameter int unsigned RowDepth   = 64,
  parameter int unsigned GroupDepth = 16,
  localparam int unsigned RowAW     = RowDepth > 1 ? $clog2(RowDepth) : 1,
  localparam int unsigned GroupAW   = GroupDepth > 1 ? $clog2(GroupDepth) : 1,
  localparam int unsigned RowCW     = $clog2(RowDepth + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          grouping_on_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire gsbo_pkg::in_item_t            in_data_i,
  // row store write
  output logic                               row_we_o,
  output logic [RowAW-1:0]                   row_waddr_o,
  output logic [GroupAW-1:0]                 row_grp_o,
  output logic [gsbo_pkg::SumW-1:0]          row_lo_o,
  output logic [gsbo_pkg::SumW-1:0]          row_hi_o,
  // group totals, read by the back end
  input  wire logic [GroupAW-1:0]            tot_raddr_i,
  output logic [gsbo_pkg::SumW-1:0]          tot_rdata_o,
  // run hand-off
  output logic                               run_valid_o,
  output logic [RowCW-1:0]                   run_rows_o,
  output logic                               run_drop_o,
  input  wire logic                          run_done_i
);

  logic [15:0]               key_q [GroupDepth];
  logic [gsbo_pkg::SumW-1:0] sum_q [GroupDepth];
  logic [GroupDepth-1:0]     use_q;
  logic [RowCW-1:0]          rows_q;
  logic                      drop_q, run_q, stage_q;
  gsbo_pkg::in_item_t        item_q;
  logic [GroupAW-1:0]        hit_idx, free_idx;
  logic                      hit, free_ok;
  logic [15:0]               key;
  logic                      accept, load_ok, row_full;
  logic [gsbo_pkg::SumW-1:0] new_sum;

  assign in_ready_o = !stage_q && !run_q;
  assign accept     = in_valid_i && in_ready_o;
  assign key        = grouping_on_i ? item_q.group_key : 16'd0;

  // Match the key or pick the lowest free slot
  always_comb begin
    hit = 1'b0; hit_idx = '0; free_ok = 1'b0; free_idx = '0;
    for (int g = GroupDepth - 1; g >= 0; g--) begin
      if (use_q[g] && key_q[g] == key) begin
        hit = 1'b1; hit_idx = GroupAW'(g);
      end
      if (!use_q[g]) begin
        free_ok = 1'b1; free_idx = GroupAW'(g);
      end
    end
  end

  assign row_full = rows_q >= RowCW'(RowDepth);
  assign load_ok  = stage_q && !row_full && (hit || free_ok);
  assign row_grp_o = hit ? hit_idx : free_idx;
  assign row_lo_o  = hit ? sum_q[hit_idx] : '0;
  assign new_sum   = row_lo_o + {{(gsbo_pkg::SumW-32){item_q.sample_value[31]}},
                                 item_q.sample_value};
  assign row_hi_o    = new_sum;
  assign row_we_o    = load_ok;
  assign row_waddr_o = rows_q[RowAW-1:0];
  assign tot_rdata_o = sum_q[tot_raddr_i];

  assign run_valid_o = run_q;
  assign run_rows_o  = rows_q;
  assign run_drop_o  = drop_q;

  // Register the request, then update the group table; clear it on run release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      run_q   <= 1'b0;
      use_q   <= '0;
      rows_q  <= '0;
      drop_q  <= 1'b0;
    end else begin
      if (accept) begin
        stage_q <= 1'b1;
      end else if (stage_q) begin
        stage_q <= 1'b0;
        if (load_ok) begin
          use_q[row_grp_o] <= 1'b1;
          rows_q <= rows_q + RowCW'(1);
        end else begin
          drop_q <= 1'b1;
        end
        if (item_q.final_row) begin
          run_q <= 1'b1;
        end
      end else if (run_q && run_done_i) begin
        run_q  <= 1'b0;
        use_q  <= '0;
        rows_q <= '0;
        drop_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (load_ok) begin
      key_q[row_grp_o] <= key;
      sum_q[row_grp_o] <= new_sum;
    end
  end

endmodule
`default_nettype wire

// ===== sv/gsbo_back.sv =====
// Emit back end: reads stored rows, applies the offset mode, drives results.
// Uses gsbo_pkg, gsbo_ram and gsbo_div.
`default_nettype none
module gsbo_back #(
  parameter int unsigned RowDepth   = 64,
  parameter int unsigned GroupDepth = 16,
  localparam int unsigned RowAW     = RowDepth > 1 ? $clog2(RowDepth) : 1,
  localparam int unsigned GroupAW   = GroupDepth > 1 ? $clog2(GroupDepth) : 1,
  localparam int unsigned RowCW     = $clog2(RowDepth + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [1:0]             offset_mode_i,
  input  wire logic                   row_we_i,
  input  wire logic [RowAW-1:0]       row_waddr_i,
  input  wire logic [GroupAW-1:0]     row_grp_i,
  input  wire logic [gsbo_pkg::SumW-1:0] row_lo_i,
  input  wire logic [gsbo_pkg::SumW-1:0] row_hi_i,
  output logic [GroupAW-1:0]          tot_raddr_o,
  input  wire logic [gsbo_pkg::SumW-1:0] tot_rdata_i,
  input  wire logic                   run_valid_i,
  input  wire logic [RowCW-1:0]       run_rows_i,
  input  wire logic                   run_drop_i,
  output logic                        run_done_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output gsbo_pkg::out_item_t         out_data_o
);

  localparam int unsigned SW      = gsbo_pkg::SumW;
  localparam int unsigned OW      = gsbo_pkg::OutW;
  localparam int unsigned RamW    = GroupAW + 2 * SW;

  gsbo_pkg::emit_state_e st_q, st_d;
  logic [RowCW-1:0]      idx_q, idx_nx;
  logic [RamW-1:0]       rd;
  logic [GroupAW-1:0]    rd_grp;
  logic signed [SW-1:0]  lo, hi, tot;
  logic                  half_sel_q, div_start, advance;
  logic signed [SW+15:0] div_num, div_quo;
  logic                  div_done;
  logic signed [OW-1:0]  lo_res_q, hi_res_q, res_lo, res_hi;
  gsbo_pkg::out_item_t   out_q;
  logic                  out_v_q, last_row;

  // Address the next row as the index moves so its data is ready in StRead
  gsbo_ram #(.Width(RamW), .Depth(RowDepth)) u_rows (
    .clk_i   (clk_i),
    .we_i    (row_we_i),
    .waddr_i (row_waddr_i),
    .wdata_i ({row_grp_i, row_lo_i, row_hi_i}),
    .raddr_i (idx_nx[RowAW-1:0]),
    .rdata_o (rd)
  );

  assign rd_grp      = rd[RamW-1 -: GroupAW];
  assign lo          = $signed(rd[2*SW-1:SW]);
  assign hi          = $signed(rd[SW-1:0]);
  assign tot_raddr_o = rd_grp;
  assign tot         = $signed(tot_rdata_i);
  assign last_row    = (idx_q + RowCW'(1)) == run_rows_i;
  assign advance     = (st_q == gsbo_pkg::StOut) && (!out_v_q || out_ready_i);
  assign idx_nx      = advance ? (last_row ? '0 : idx_q + RowCW'(1)) : idx_q;

  // Lower edge is divided first from StRead, upper edge second from StDiv
  assign div_num = $signed({(st_q == gsbo_pkg::StDiv) ? hi : lo, 16'd0});
  assign div_start = (st_q == gsbo_pkg::StRead) ||
                     (st_q == gsbo_pkg::StDiv && div_done && !half_sel_q);

  gsbo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start && offset_mode_i == gsbo_pkg::ModeNormalize && tot != '0),
    .num_i   (div_num),
    .den_i   (tot),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  function automatic logic signed [OW-1:0] sat_f(input logic signed [SW+15:0] x);
    logic signed [SW+15:0] mx, mn;
    mx = (SW+16)'({1'b0, {(OW-1){1'b1}}});
    mn = ~mx;
    if (x > mx) return mx[OW-1:0];
    if (x < mn) return mn[OW-1:0];
    return x[OW-1:0];
  endfunction

  // Form both edges for the zero and centre modes; normalize mode zeroes them here
  always_comb begin
    logic signed [SW-1:0] half;
    half = $signed(tot + SW'(tot[SW-1])) >>> 1;
    res_lo = OW'(lo);
    res_hi = OW'(hi);
    if (offset_mode_i == gsbo_pkg::ModeCenter) begin
      res_lo = OW'(lo) - OW'(half);
      res_hi = OW'(hi) - OW'(half);
    end else if (offset_mode_i == gsbo_pkg::ModeNormalize) begin
      res_lo = '0;
      res_hi = '0;
    end
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      gsbo_pkg::StIdle: begin
        if (run_valid_i && run_rows_i != '0) st_d = gsbo_pkg::StRead;
      end
      gsbo_pkg::StRead: begin
        if (offset_mode_i == gsbo_pkg::ModeNormalize && tot != '0) begin
          st_d = gsbo_pkg::StDiv;
        end else begin
          st_d = gsbo_pkg::StOut;
        end
      end
      gsbo_pkg::StDiv: begin
        if (div_done && half_sel_q) st_d = gsbo_pkg::StOut;
      end
      gsbo_pkg::StOut: begin
        if (!out_v_q || out_ready_i) begin
          st_d = last_row ? gsbo_pkg::StIdle : gsbo_pkg::StRead;
        end
      end
      default: st_d = gsbo_pkg::StIdle;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    run_done_o = 1'b0;
    unique case (st_q)
      gsbo_pkg::StIdle: run_done_o = run_valid_i && run_rows_i == '0;
      gsbo_pkg::StOut:  run_done_o = (!out_v_q || out_ready_i) && last_row;
      default:          run_done_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= gsbo_pkg::StIdle;
      idx_q      <= '0;
      out_v_q    <= 1'b0;
      half_sel_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_nx;
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (st_q == gsbo_pkg::StRead) half_sel_q <= 1'b0;
      if (st_q == gsbo_pkg::StDiv && div_done) half_sel_q <= 1'b1;
      if (advance) out_v_q <= 1'b1;
    end
  end

  // Capture edges and load the result register only when it is empty or being taken
  always_ff @(posedge clk_i) begin
    if (st_q == gsbo_pkg::StRead) begin
      lo_res_q <= res_lo;
      hi_res_q <= res_hi;
    end
    if (st_q == gsbo_pkg::StDiv && div_done) begin
      if (!half_sel_q) lo_res_q <= sat_f(div_quo);
      else hi_res_q <= sat_f(div_quo);
    end
    if (advance) begin
      out_q.band_lower    <= lo_res_q;
      out_q.band_upper    <= hi_res_q;
      out_q.end_of_run    <= last_row;
      out_q.capacity_flag <= run_drop_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != gsbo_pkg::StIdle |-> idx_q < run_rows_i)
    else $error("row index beyond run length");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_done_o |=> !run_done_o)
    else $error("run released twice");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_ready_i |=> out_v_q && $stable(out_q))
    else $error("result changed while stalled");

endmodule
`default_nettype wire

// ===== sv/grouped_stack_band_offset.sv =====
// Loading: a row passes the request register, then the group update; the next
// row is taken after that update. A final row starts emission; each result goes
// through StRead and StOut, with two bit-serial divides in StDiv between them in
// normalize mode. Reset clears the group valid bits, row count, flags and control
// registers; no sweep. Input is not taken while a run is being emitted.
`default_nettype none
module grouped_stack_band_offset #(
  parameter int unsigned ROW_DEPTH   = 64,
  parameter int unsigned GROUP_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire gsbo_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output gsbo_pkg::out_item_t      out_data_o
);

  localparam int unsigned RowAW   = ROW_DEPTH > 1 ? $clog2(ROW_DEPTH) : 1;
  localparam int unsigned GroupAW = GROUP_DEPTH > 1 ? $clog2(GROUP_DEPTH) : 1;
  localparam int unsigned RowCW   = $clog2(ROW_DEPTH + 1);

  logic [1:0] mode_q;
  logic       grp_q, wr;
  logic                      row_we, run_valid, run_drop, run_done;
  logic [RowAW-1:0]          row_waddr;
  logic [GroupAW-1:0]        row_grp, tot_raddr;
  logic [gsbo_pkg::SumW-1:0] row_lo, row_hi, tot_rdata;
  logic [RowCW-1:0]          run_rows;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= gsbo_pkg::ModeZero;
      grp_q  <= 1'b0;
    end else if (wr && paddr[2] == gsbo_pkg::RegOffsetMode && paddr[1:0] == 2'd0) begin
      mode_q <= pwdata[1:0];
    end else if (wr && paddr[2] == gsbo_pkg::RegGrouping && paddr[1:0] == 2'd0) begin
      grp_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == gsbo_pkg::RegGrouping) ? {31'd0, grp_q} : {30'd0, mode_q};

  gsbo_front #(.RowDepth(ROW_DEPTH), .GroupDepth(GROUP_DEPTH)) u_front (
    .clk_i, .rst_ni,
    .grouping_on_i (grp_q),
    .in_valid_i, .in_ready_o, .in_data_i,
    .row_we_o (row_we), .row_waddr_o (row_waddr), .row_grp_o (row_grp),
    .row_lo_o (row_lo), .row_hi_o (row_hi),
    .tot_raddr_i (tot_raddr), .tot_rdata_o (tot_rdata),
    .run_valid_o (run_valid), .run_rows_o (run_rows), .run_drop_o (run_drop),
    .run_done_i (run_done)
  );

  gsbo_back #(.RowDepth(ROW_DEPTH), .GroupDepth(GROUP_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .offset_mode_i (mode_q),
    .row_we_i (row_we), .row_waddr_i (row_waddr), .row_grp_i (row_grp),
    .row_lo_i (row_lo), .row_hi_i (row_hi),
    .tot_raddr_o (tot_raddr), .tot_rdata_i (tot_rdata),
    .run_valid_i (run_valid), .run_rows_i (run_rows), .run_drop_i (run_drop),
    .run_done_o (run_done),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
`default_nettype wire
